FILE: rtl/core/lmr_pkg.sv
// Shared types, constants and control bundles for the line rasterizer core.
`default_nettype none
package lmr_pkg;

  localparam int COORD_BITS = 12;
  localparam int DEC_BITS   = COORD_BITS + 4;
  localparam int COLOR_BITS = 24;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;
  typedef logic [COLOR_BITS-1:0]      color_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic emit;
  } lmr_cmd_t;

  typedef struct packed {
    logic line_active;
  } lmr_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/lmr_ctrl.sv
// Controller state machine sequencing line setup and pixel emission.
`default_nettype none
module lmr_ctrl
  import lmr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        func,
  input  wire lmr_status_t status,
  output lmr_cmd_t         cmd,
  output logic             busy
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PREP  = 2'd1;
  localparam logic [1:0] ST_FIRST = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        if (accept && func == FUNC_START) begin
          cmd.capture = 1'b1;
          state_next  = ST_PREP;
        end else if (accept && func == FUNC_ADVANCE && status.line_active) begin
          cmd.emit = 1'b1;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_FIRST;
      end
      ST_FIRST: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/lmr_datapath.sv
// Datapath: endpoint deltas, decision terms, pixel stepping and result register.
`default_nettype none
module lmr_datapath
  import lmr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire lmr_cmd_t cmd,
  output lmr_status_t   status,
  input  wire coord_t   start_x,
  input  wire coord_t   start_y,
  input  wire coord_t   end_x,
  input  wire coord_t   end_y,
  input  wire logic     cfg_valid,
  input  wire color_t   draw_color,
  output logic          pixel_valid,
  output coord_t        pixel_x,
  output coord_t        pixel_y,
  output color_t        pixel_color,
  output logic          last_pixel
);

  color_t color;

  coord_t e_sx, e_sy, e_ex, e_ey;
  coord_t adx, ady;
  logic   dx_neg, dy_neg;

  logic   active;
  coord_t cur_x, cur_y, stop_major;
  dec_t   decision, add_minor, add_major;
  logic   minor_negative, major_is_x;

  logic [COORD_BITS:0] dx_w, dy_w, ndx_w, ndy_w;
  coord_t adx_w, ady_w;

  logic   p_mx, p_swap, p_minor_neg;
  coord_t p_big, p_small;
  dec_t   p_big_e, p_small2;

  coord_t major, minor, major_inc, minor_step;
  logic   last, step_minor;

  assign status.line_active = active;

  assign dx_w  = {1'b0, end_x} - {1'b0, start_x};
  assign dy_w  = {1'b0, end_y} - {1'b0, start_y};
  assign ndx_w = -dx_w;
  assign ndy_w = -dy_w;
  assign adx_w = dx_w[COORD_BITS] ? ndx_w[COORD_BITS-1:0] : dx_w[COORD_BITS-1:0];
  assign ady_w = dy_w[COORD_BITS] ? ndy_w[COORD_BITS-1:0] : dy_w[COORD_BITS-1:0];

  assign p_mx    = (ady <= adx);
  assign p_swap  = p_mx ? dx_neg : dy_neg;
  assign p_big   = p_mx ? adx : ady;
  assign p_small = p_mx ? ady : adx;
  assign p_minor_neg = p_mx ? (p_swap ? ((ady != '0) && !dy_neg) : dy_neg)
                            : (p_swap ? ((adx != '0) && !dx_neg) : dx_neg);
  assign p_big_e  = dec_t'({4'b0000, p_big});
  assign p_small2 = dec_t'({3'b000, p_small, 1'b0});

  assign major      = major_is_x ? cur_x : cur_y;
  assign minor      = major_is_x ? cur_y : cur_x;
  assign last       = (major == stop_major);
  assign step_minor = (decision <= 0);
  assign major_inc  = major + coord_t'(1);
  assign minor_step = !step_minor ? minor :
                      (minor_negative ? minor - coord_t'(1) : minor + coord_t'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      color <= '0;
    end else if (cfg_valid) begin
      color <= draw_color;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      e_sx   <= start_x;
      e_sy   <= start_y;
      e_ex   <= end_x;
      e_ey   <= end_y;
      adx    <= adx_w;
      ady    <= ady_w;
      dx_neg <= dx_w[COORD_BITS];
      dy_neg <= dy_w[COORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cmd.capture) begin
      active <= 1'b0;
    end else if (cmd.prep) begin
      active <= 1'b1;
    end else if (cmd.emit) begin
      active <= !last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      major_is_x     <= p_mx;
      minor_negative <= p_minor_neg;
      cur_x          <= p_swap ? e_ex : e_sx;
      cur_y          <= p_swap ? e_ey : e_sy;
      stop_major     <= p_mx ? (p_swap ? e_sx : e_ex) : (p_swap ? e_sy : e_ey);
      decision       <= p_big_e - p_small2;
      add_minor      <= dec_t'({3'b000, p_big, 1'b0}) - p_small2;
      add_major      <= -p_small2;
    end else if (cmd.emit && !last) begin
      decision <= decision + (step_minor ? add_minor : add_major);
      if (major_is_x) begin
        cur_x <= major_inc;
        cur_y <= minor_step;
      end else begin
        cur_y <= major_inc;
        cur_x <= minor_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      pixel_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_x     <= cur_x;
      pixel_y     <= cur_y;
      pixel_color <= color;
      last_pixel  <= last;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/line_midpoint_rasterizer_core.sv
// Top level of the midpoint line rasterizer: controller, datapath and checks.
//
// channel   direction  handshake                 payload
// command   in         start, busy               func, start_x, start_y, end_x, end_y
// config    in         cfg_valid, cfg_ready      draw_color
// pixel     out        pixel_valid (strobe)      pixel_x, pixel_y, pixel_color, last_pixel
//
// An advance command's pixel shows in the next cycle, and busy stays low, so advances
// may follow every cycle. A start command captures the deltas in the transfer cycle,
// then holds busy through setup of the decision terms and the first emit, whose pixel
// then shows from the pixel register. Synchronous reset clears the line and the color.
// Each pixel is on the ports for one cycle; the receiver cannot stall the block.
`default_nettype none
module line_midpoint_rasterizer_core
  import lmr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  output logic        busy,
  input  wire logic   func,
  input  wire coord_t start_x,
  input  wire coord_t start_y,
  input  wire coord_t end_x,
  input  wire coord_t end_y,
  input  wire logic   cfg_valid,
  output logic        cfg_ready,
  input  wire color_t draw_color,
  output logic        pixel_valid,
  output coord_t      pixel_x,
  output coord_t      pixel_y,
  output color_t      pixel_color,
  output logic        last_pixel
);

  lmr_cmd_t    cmd;
  lmr_status_t status;

  assign cfg_ready = 1'b1;

  lmr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  lmr_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .cfg_valid   (cfg_valid),
    .draw_color  (draw_color),
    .pixel_valid (pixel_valid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last_pixel  (last_pixel)
  );

  a_start_first_pixel: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FUNC_START) |-> ##3 pixel_valid)
    else $error("start transfer did not yield a first pixel");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && last_pixel) |-> !status.line_active)
    else $error("line still active after last pixel");

  a_no_pixel_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !pixel_valid)
    else $error("pixel emitted during line setup");

  a_idle_advance_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FUNC_ADVANCE && !status.line_active) |=> !pixel_valid)
    else $error("advance while idle produced a pixel");

endmodule
`default_nettype wire
